// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define VAD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define VAD_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== design/vad_pkg.sv =====
// Shared constants, register codes and transaction types of the voice activity detector.
package vad_pkg;

  localparam int MAX_FRAME   = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(MAX_FRAME);
  localparam int FRAME_W = $clog2(MAX_FRAME + 1);
  localparam int PTR_W   = $clog2(2 * MAX_FRAME);
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W   = 2 * SAMPLE_BITS - 2 + FRAME_W;
  localparam int CNT_W   = FRAME_W;

  localparam int LEN_W  = 13;
  localparam int THR_W  = 31;
  localparam int RATE_W = 17;
  localparam int TOT_W  = 32;

  localparam int THR_F_W    = THR_W + FRAME_W;
  localparam int RATE_P_W   = RATE_W + FRAME_W;
  localparam int RATE_SHIFT = 16;
  localparam int RATE_CMP_W = (RATE_P_W > CNT_W + RATE_SHIFT) ? RATE_P_W
                                                              : CNT_W + RATE_SHIFT;
  localparam int ECMP_W     = (SUM_W > THR_F_W) ? SUM_W : THR_F_W;

  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [LEN_W-1:0]  FRAME_LEN_RST = 13'd1024;
  localparam logic [LEN_W-1:0]  HOP_LEN_RST   = 13'd512;
  localparam logic [THR_W-1:0]  THR_SQ_RST    = 31'd429497;
  localparam logic [RATE_W-1:0] RATE_MIN_RST  = 17'd655;
  localparam logic [RATE_W-1:0] RATE_MAX_RST  = 17'd22938;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_LEN = 3'd0,
    REG_HOP_LEN   = 3'd1,
    REG_THR_SQ    = 3'd2,
    REG_RATE_MIN  = 3'd3,
    REG_RATE_MAX  = 3'd4
  } vad_reg_e;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_len;
    logic [FRAME_W-1:0]  hop_len;
    logic                f_ge2;
    logic [THR_F_W-1:0]  thr_f;
    logic [RATE_P_W-1:0] min_d;
    logic [RATE_P_W-1:0] max_d;
    logic                min_zero;
    logic                cfg_err;
    logic                clear;
  } vad_cfg_t;

  typedef struct packed {
    logic             due;
    logic             eos;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] crossings;
  } vad_req_t;

  typedef struct packed {
    logic             frame_valid;
    logic             frame_voiced;
    logic [TOT_W-1:0] voiced_frames;
    logic [TOT_W-1:0] total_frames;
    logic             config_error;
    logic             stream_done;
  } vad_res_t;

endpackage

// ===== design/rms_zcr_voice_activity_detector_unit.sv =====
// A sample's result shows (empty low) after the front-end registers and both queues.
// Throughput: one sample per cycle unless full; one store read and one write per sample.
// Samples that close no frame and do not end the stream produce no result.
// Reset: control state, sums, counters and queues clear at once; the store is not cleared,
// since only entries written in the current window are ever read.
// Top level of the energy and zero-crossing voice activity detector.
module rms_zcr_voice_activity_detector_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [vad_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                end_of_stream_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                frame_valid_o,
  output logic                                frame_voiced_o,
  output logic [vad_pkg::TOT_W-1:0]           voiced_frames_o,
  output logic [vad_pkg::TOT_W-1:0]           total_frames_o,
  output logic                                config_error_o,
  output logic                                stream_done_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vad_pkg::PADDR_W-1:0]         paddr,
  input  logic [vad_pkg::DATA_W-1:0]          pwdata,
  output logic [vad_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import vad_pkg::*;

  vad_cfg_t             cfg;
  vad_req_t             req_in, req_out;
  vad_res_t             res;
  logic                 req_valid, req_empty, req_pop;
  logic [MID_CNT_W-1:0] mid_cnt;

  vad_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vad_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .sample_i        (sample_i),
    .end_of_stream_i (end_of_stream_i),
    .cfg_i           (cfg),
    .mid_cnt_i       (mid_cnt),
    .req_valid_o     (req_valid),
    .req_o           (req_in)
  );

  vad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (req_valid),
    .data_i  (req_in),
    .rd_i    (req_pop),
    .data_o  (req_out),
    .empty_o (req_empty),
    .count_o (mid_cnt)
  );

  vad_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_out),
    .req_empty_i (req_empty),
    .req_pop_o   (req_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign frame_valid_o   = res.frame_valid;
  assign frame_voiced_o  = res.frame_voiced;
  assign voiced_frames_o = res.voiced_frames;
  assign total_frames_o  = res.total_frames;
  assign config_error_o  = res.config_error;
  assign stream_done_o   = res.stream_done;

endmodule

// ===== design/vad_regs.sv =====
// Configuration registers, APB access and derived frame settings.
module vad_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vad_pkg::PADDR_W-1:0]  paddr,
  input  logic [vad_pkg::DATA_W-1:0]   pwdata,
  output logic [vad_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output vad_pkg::vad_cfg_t            cfg_o
);
  import vad_pkg::*;

  logic [LEN_W-1:0]    frame_len_q, hop_len_q;
  logic [THR_W-1:0]    thr_q;
  logic [RATE_W-1:0]   rmin_q, rmax_q;
  logic [THR_F_W-1:0]  thr_f_q;
  logic [RATE_P_W-1:0] min_d_q, max_d_q;
  logic [FRAME_W-1:0]  f_len, h_len, f_m1;
  logic                wr_en;
  vad_reg_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = vad_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FRAME_LEN_RST;
      hop_len_q   <= HOP_LEN_RST;
      thr_q       <= THR_SQ_RST;
      rmin_q      <= RATE_MIN_RST;
      rmax_q      <= RATE_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_LEN: frame_len_q <= pwdata[LEN_W-1:0];
        REG_HOP_LEN:   hop_len_q   <= pwdata[LEN_W-1:0];
        REG_THR_SQ:    thr_q       <= pwdata[THR_W-1:0];
        REG_RATE_MIN:  rmin_q      <= pwdata[RATE_W-1:0];
        REG_RATE_MAX:  rmax_q      <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (frame_len_q == '0) begin
      f_len = FRAME_W'(1);
    end else if (32'(frame_len_q) > MAX_FRAME) begin
      f_len = FRAME_W'(MAX_FRAME);
    end else begin
      f_len = FRAME_W'(frame_len_q);
    end
    priority if (hop_len_q == '0) begin
      h_len = FRAME_W'(1);
    end else if (32'(hop_len_q) > 32'(f_len)) begin
      h_len = f_len;
    end else begin
      h_len = FRAME_W'(hop_len_q);
    end
  end

  assign f_m1 = f_len - FRAME_W'(1);

  // threshold products, registered from the current settings
  always_ff @(posedge clk_i) begin
    thr_f_q <= THR_F_W'(thr_q) * THR_F_W'(f_len);
    min_d_q <= RATE_P_W'(rmin_q) * RATE_P_W'(f_m1);
    max_d_q <= RATE_P_W'(rmax_q) * RATE_P_W'(f_m1);
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_LEN: prdata = DATA_W'(frame_len_q);
      REG_HOP_LEN:   prdata = DATA_W'(hop_len_q);
      REG_THR_SQ:    prdata = DATA_W'(thr_q);
      REG_RATE_MIN:  prdata = DATA_W'(rmin_q);
      REG_RATE_MAX:  prdata = DATA_W'(rmax_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.frame_len = f_len;
  assign cfg_o.hop_len   = h_len;
  assign cfg_o.f_ge2     = (f_len != FRAME_W'(1));
  assign cfg_o.thr_f     = thr_f_q;
  assign cfg_o.min_d     = min_d_q;
  assign cfg_o.max_d     = max_d_q;
  assign cfg_o.min_zero  = (rmin_q == '0);
  assign cfg_o.cfg_err   = (rmin_q > rmax_q);
  assign cfg_o.clear     = wr_en && (idx == REG_FRAME_LEN || idx == REG_HOP_LEN);

endmodule

// ===== design/vad_front.sv =====
// Front end: sample store, sliding square sum, crossing count and frame scheduling.
module vad_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [vad_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                              end_of_stream_i,
  input  vad_pkg::vad_cfg_t                 cfg_i,
  input  logic [vad_pkg::MID_CNT_W-1:0]     mid_cnt_i,
  output logic                              req_valid_o,
  output vad_pkg::vad_req_t                 req_o
);
  import vad_pkg::*;

  logic signed [SAMPLE_BITS-1:0] store_mem [MAX_FRAME];

  logic                          accept;
  logic [MID_CNT_W:0]            pend;
  logic [ADDR_W-1:0]             wp_q, wp_d, raddr;
  logic [PTR_W-1:0]              rtmp;
  logic [FRAME_W-1:0]            fill_q, fill_d, hop_q, hop_d, fill_inc, hop_inc;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic                          win_full, due, add_cross;
  logic signed [2*SAMPLE_BITS-1:0] in_sq, rd_sq;

  logic                          a_valid_q;
  logic signed [SAMPLE_BITS-1:0] a_sample_q, rdata_q, head_q;
  logic [SQ_W-1:0]               a_sq_q, head_sq_q, rem_sq;
  logic                          a_eos_q, a_due_q, a_full_q, a_first_q, a_add_q;
  logic                          rem_cross;
  logic [SUM_W-1:0]              sum_q, sum_new;
  logic [CNT_W-1:0]              cross_q, cross_new;

  assign pend   = {1'b0, mid_cnt_i} + {{MID_CNT_W{1'b0}}, a_valid_q};
  assign full   = (pend >= (MID_CNT_W + 1)'(MID_DEPTH));
  assign accept = push & ~full;

  assign win_full = (fill_q >= cfg_i.frame_len);
  assign fill_inc = fill_q + FRAME_W'(1);
  assign hop_inc  = hop_q + FRAME_W'(1);
  assign add_cross = cfg_i.f_ge2 && (fill_q != '0) &&
                     (prev_q[SAMPLE_BITS-1] != sample_i[SAMPLE_BITS-1]);
  assign in_sq = sample_i * sample_i;
  assign rd_sq = rdata_q * rdata_q;

  always_comb begin
    fill_d = fill_q;
    hop_d  = hop_q;
    due    = 1'b0;
    if (win_full) begin
      if (hop_inc >= cfg_i.hop_len) begin
        hop_d = '0;
        due   = 1'b1;
      end else begin
        hop_d = hop_inc;
      end
    end else begin
      fill_d = fill_inc;
      priority if (fill_inc >= cfg_i.frame_len) begin
        hop_d = '0;
        due   = 1'b1;
      end else if (end_of_stream_i) begin
        due = 1'b1;
      end else begin
        due = 1'b0;
      end
    end
    if (end_of_stream_i) begin
      fill_d = '0;
      hop_d  = '0;
    end
  end

  // the oldest entry of the window once this sample is in
  always_comb begin
    rtmp = PTR_W'(wp_q) + PTR_W'(MAX_FRAME) - PTR_W'(cfg_i.frame_len) + PTR_W'(1);
    if (rtmp >= PTR_W'(MAX_FRAME)) begin
      rtmp = rtmp - PTR_W'(MAX_FRAME);
    end
    raddr = rtmp[ADDR_W-1:0];
  end

  assign wp_d = (wp_q == ADDR_W'(MAX_FRAME - 1)) ? '0 : wp_q + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_mem[wp_q] <= sample_i;
      rdata_q         <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      fill_q    <= '0;
      hop_q     <= '0;
      prev_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept;
      if (accept) begin
        wp_q <= wp_d;
      end
      if (cfg_i.clear) begin
        fill_q <= '0;
        hop_q  <= '0;
        prev_q <= '0;
      end else if (accept) begin
        fill_q <= fill_d;
        hop_q  <= hop_d;
        prev_q <= end_of_stream_i ? '0 : sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= sample_i;
      a_sq_q     <= in_sq[SQ_W-1:0];
      a_eos_q    <= end_of_stream_i;
      a_due_q    <= due;
      a_full_q   <= win_full;
      a_first_q  <= (fill_q == '0);
      a_add_q    <= add_cross;
    end
  end

  // window update in the cycle after accept, once the store read is back
  assign rem_sq    = a_full_q ? head_sq_q : '0;
  assign sum_new   = sum_q + SUM_W'(a_sq_q) - SUM_W'(rem_sq);
  assign rem_cross = a_full_q && cfg_i.f_ge2 &&
                     (head_q[SAMPLE_BITS-1] != rdata_q[SAMPLE_BITS-1]);
  assign cross_new = cross_q + CNT_W'(a_add_q) - CNT_W'(rem_cross);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cross_q <= '0;
    end else if (cfg_i.clear) begin
      sum_q   <= '0;
      cross_q <= '0;
    end else if (a_valid_q) begin
      sum_q   <= a_eos_q ? '0 : sum_new;
      cross_q <= a_eos_q ? '0 : cross_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      priority if (a_first_q || (a_full_q && !cfg_i.f_ge2)) begin
        head_q    <= a_sample_q;
        head_sq_q <= a_sq_q;
      end else if (a_full_q) begin
        head_q    <= rdata_q;
        head_sq_q <= rd_sq[SQ_W-1:0];
      end else begin
        head_q    <= head_q;
        head_sq_q <= head_sq_q;
      end
    end
  end

  assign req_valid_o     = a_valid_q && (a_due_q || a_eos_q);
  assign req_o.due       = a_due_q;
  assign req_o.eos       = a_eos_q;
  assign req_o.sum       = sum_new;
  assign req_o.crossings = cross_new;

endmodule

// ===== design/vad_queue.sv =====
// Short queue of frame requests between the front end and the judge.
module vad_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  vad_pkg::vad_req_t             data_i,
  input  logic                          rd_i,
  output vad_pkg::vad_req_t             data_o,
  output logic                          empty_o,
  output logic [vad_pkg::MID_CNT_W-1:0] count_o
);
  import vad_pkg::*;

  vad_req_t             slot_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] rd_q, wr_q;
  logic [MID_CNT_W-1:0] cnt_q;
  logic                 do_rd;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = slot_q[rd_q];
  assign do_rd   = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wr_q <= (wr_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_q + MID_PTR_W'(1);
      end
      if (do_rd) begin
        rd_q <= (rd_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_q + MID_PTR_W'(1);
      end
      cnt_q <= cnt_q + MID_CNT_W'(wr_i) - MID_CNT_W'(do_rd);
    end
  end

endmodule

// ===== design/vad_judge.sv =====
// Back end: energy and crossing-rate tests, frame counters and result queue.
module vad_judge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vad_pkg::vad_cfg_t cfg_i,
  input  vad_pkg::vad_req_t req_i,
  input  logic              req_empty_i,
  output logic              req_pop_o,
  input  logic              pop,
  output logic              empty,
  output vad_pkg::vad_res_t res_o
);
  import vad_pkg::*;

  vad_res_t             out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] rd_q, wr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic [TOT_W-1:0]     vt_q, ft_q, vt_new, ft_new;
  logic                 out_pop, take, energy_ok, rate_ok, judged, voiced;
  logic [RATE_CMP_W-1:0] c_scaled;
  vad_res_t             res_new;

  assign empty   = (cnt_q == '0);
  assign out_pop = pop && !empty;
  assign take    = !req_empty_i && ((cnt_q < OUT_CNT_W'(OUT_DEPTH)) || out_pop);
  assign req_pop_o = take;

  assign energy_ok = (ECMP_W'(req_i.sum) >= ECMP_W'(cfg_i.thr_f));
  assign c_scaled  = RATE_CMP_W'(req_i.crossings) << RATE_SHIFT;
  assign rate_ok   = cfg_i.f_ge2 ? ((c_scaled >= RATE_CMP_W'(cfg_i.min_d)) &&
                                    (c_scaled <= RATE_CMP_W'(cfg_i.max_d)))
                                 : cfg_i.min_zero;
  assign judged    = req_i.due && !cfg_i.cfg_err;
  assign voiced    = judged && energy_ok && rate_ok;

  assign ft_new = (judged && ft_q != '1) ? ft_q + TOT_W'(1) : ft_q;
  assign vt_new = (voiced && vt_q != '1) ? vt_q + TOT_W'(1) : vt_q;

  assign res_new.frame_valid   = req_i.due;
  assign res_new.frame_voiced  = voiced;
  assign res_new.voiced_frames = vt_new;
  assign res_new.total_frames  = ft_new;
  assign res_new.config_error  = cfg_i.cfg_err;
  assign res_new.stream_done   = req_i.eos;

  assign res_o = out_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q[wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q  <= '0;
      ft_q  <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (take) begin
        vt_q <= req_i.eos ? '0 : vt_new;
        ft_q <= req_i.eos ? '0 : ft_new;
        wr_q <= (wr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_q + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_q <= (rd_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_q + OUT_PTR_W'(1);
      end
      cnt_q <= cnt_q + OUT_CNT_W'(take) - OUT_CNT_W'(out_pop);
    end
  end

endmodule

// ===== design/vad_checker.sv =====
// Port-level checker for the voice activity detector, bound to the top level.
`include "assert_macros.svh"

module vad_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic                        frame_valid_o,
  input logic                        frame_voiced_o,
  input logic [vad_pkg::TOT_W-1:0]   voiced_frames_o,
  input logic [vad_pkg::TOT_W-1:0]   total_frames_o,
  input logic                        config_error_o,
  input logic                        stream_done_o
);

  `VAD_ASSERT(result_held, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(frame_voiced_o) && $stable(voiced_frames_o) && $stable(total_frames_o))

  `VAD_ASSERT(voiced_is_judged, clk_i, rst_ni, !empty && frame_voiced_o |-> frame_valid_o && !config_error_o)

  `VAD_ASSERT(no_frame_only_at_end, clk_i, rst_ni, !empty && !frame_valid_o |-> stream_done_o)

  `VAD_ASSERT(voiced_within_total, clk_i, rst_ni, !empty |-> voiced_frames_o <= total_frames_o)

  `VAD_ASSERT_NR(empty_in_reset, clk_i, !rst_ni |-> empty)

endmodule

bind rms_zcr_voice_activity_detector_unit vad_checker u_checker (.*);
